// ===== design/nic_pkg.sv =====
//------------------------------------------------------------------------------
// nic_pkg
// Types and constants for the nearest-in-vision-cone query block.
//------------------------------------------------------------------------------
package nic_pkg;

	localparam int SLOTS       = 64;
	localparam int SLOT_BITS   = 6;
	localparam int COORD_BITS  = 24;
	localparam int CORDIC_STEPS = 15;
	localparam int CW          = 48;
	localparam int STEP_BITS   = 4;

	localparam logic signed [CW-1:0] NORM_FLOOR = 48'sh0100_0000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  slot;
		logic        live;
		logic        self_in_table;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] heading;
		logic signed [15:0] turn_offset;
		logic [15:0] aperture;
		logic [22:0] range_limit;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  nearest_slot;
		logic [48:0] dist_sq;
	} rsp_t;

	function automatic logic [15:0] atan_tab(input logic [STEP_BITS-1:0] i);
		logic [15:0] r;
		case (i)
			4'd0:  r = 16'd8192;
			4'd1:  r = 16'd4836;
			4'd2:  r = 16'd2555;
			4'd3:  r = 16'd1297;
			4'd4:  r = 16'd651;
			4'd5:  r = 16'd326;
			4'd6:  r = 16'd163;
			4'd7:  r = 16'd81;
			4'd8:  r = 16'd41;
			4'd9:  r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			4'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/nic_ram.sv =====
//------------------------------------------------------------------------------
// nic_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
module nic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== design/nearest_in_vision_cone.sv =====
//------------------------------------------------------------------------------
// nearest_in_vision_cone
// Slot table of object positions with a nearest-in-cone search.
//------------------------------------------------------------------------------
// Usage: drive req and raise start while busy is low; the request is taken on
// that edge. A write request (opcode 0) holds busy high while it updates one
// slot and gives no result; the next request is taken only once busy is low.
// A query request (opcode 1) walks all 64 slots. A slot that is not live or
// is the observer's own is skipped. Any other slot goes through RAM read,
// difference, magnitude, squaring, then sum with range/best compares.
// If the entry is in range and closer than the best so far, a bearing run
// follows: a setup step, a normalize loop of up to 40 doublings, 15 CORDIC
// micro-rotations on one shared add/subtract unit and a cone test.
// The result appears on rsp with done high for exactly one cycle, the first
// cycle with busy low; the next request can be taken at the edge that ends
// that cycle. The receiver cannot stall, so it must take the result then.
// Reset clears the live bits and the sequencer; positions are undefined until
// written. No clearing pass is needed.
//------------------------------------------------------------------------------
module nearest_in_vision_cone
	import nic_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_WR    = 11'b00000000010,
		ST_RD    = 11'b00000000100,
		ST_DIFF  = 11'b00000001000,
		ST_SQ    = 11'b00000010000,
		ST_MUL   = 11'b00000100000,
		ST_CMP   = 11'b00001000000,
		ST_CSET  = 11'b00010000000,
		ST_NORM  = 11'b00100000000,
		ST_ROT   = 11'b01000000000,
		ST_CONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [SLOTS-1:0] live_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic [SLOT_BITS-1:0] ram_addr;
	logic ram_we;
	logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;

	logic signed [COORD_BITS:0] dx_q, dy_q;
	logic [COORD_BITS-1:0] ax_q, ay_q;
	logic [2*COORD_BITS-1:0] sqx_q, sqy_q;
	logic [2*COORD_BITS:0] d_q;
	logic [45:0] rsq_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [15:0] z_q;
	logic [STEP_BITS-1:0] it_q;
	logic found_q;
	logic [SLOT_BITS-1:0] best_slot_q;
	logic [2*COORD_BITS:0] best_q;
	logic done_q;
	rsp_t rsp_q;

	logic [SLOT_BITS-1:0] cur;
	assign cur = idx_q;
	assign ram_we = (state_q == ST_WR) && req_q.live;
	assign ram_addr = (state_q == ST_WR) ? req_q.slot : cur;
	assign ram_wdata = {req_q.pos_x, req_q.pos_y};

	nic_ram #(.WIDTH(2*COORD_BITS), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// shared CORDIC add/subtract unit
	logic signed [CW-1:0] xs, ys, nx, ny;
	logic [15:0] nz, rel, amag;
	logic ydir;
	logic norm_done;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign ydir = ~cy_q[CW-1];
	assign nx = ydir ? cx_q + ys : cx_q - ys;
	assign ny = ydir ? cy_q - xs : cy_q + xs;
	assign nz = ydir ? z_q + atan_tab(it_q) : z_q - atan_tab(it_q);
	assign norm_done = (cx_q >= NORM_FLOOR) || (cy_q >= NORM_FLOOR)
		|| (cy_q <= -NORM_FLOOR);
	assign rel = z_q - req_q.heading - req_q.turn_offset;
	assign amag = rel[15] ? 16'(-rel) : rel;

	logic [2*COORD_BITS:0] d_sum;
	assign d_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	logic skip, in_range, closer;
	assign skip = !live_q[cur] || (req_q.self_in_table && req_q.slot == cur);
	assign in_range = (req_q.range_limit == '0) || (d_sum < {3'b0, rsq_q});
	assign closer = !found_q || (d_sum < best_q);

	logic last;
	assign last = (idx_q == SLOT_BITS'(SLOTS-1));

	logic cone_ok;
	assign cone_ok = (req_q.aperture == '0) || ({amag, 1'b0} <= {1'b0, req_q.aperture});

	logic slot_end, query_end;
	assign slot_end = (state_q == ST_RD && skip)
		|| (state_q == ST_CMP && !(in_range && closer)) || (state_q == ST_CONE);
	assign query_end = slot_end && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q  <= '0;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= query_end;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						state_q <= (req.opcode == OP_WRITE) ? ST_WR : ST_RD;
					end
				end
				ST_WR: begin
					live_q[req_q.slot] <= req_q.live;
					state_q <= ST_IDLE;
				end
				ST_RD: state_q <= skip ? (last ? ST_IDLE : ST_RD) : ST_DIFF;
				ST_DIFF: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: state_q <= (in_range && closer) ? ST_CSET
					: (last ? ST_IDLE : ST_RD);
				ST_CSET: state_q <= ST_NORM;
				ST_NORM: if (norm_done || (dx_q == '0 && dy_q == '0)) state_q <= ST_ROT;
				ST_ROT: if (it_q == STEP_BITS'(CORDIC_STEPS-1)) state_q <= ST_CONE;
				ST_CONE: state_q <= last ? ST_IDLE : ST_RD;
				default: state_q <= ST_IDLE;
			endcase
			if (slot_end)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q <= req;
					rsq_q <= req.range_limit * req.range_limit;
					found_q <= 1'b0;
					best_q <= '0;
					best_slot_q <= '0;
				end
			end
			ST_DIFF: begin
				dx_q <= (COORD_BITS+1)'($signed(ram_rdata[2*COORD_BITS-1:COORD_BITS]))
					- (COORD_BITS+1)'(req_q.pos_x);
				dy_q <= (COORD_BITS+1)'($signed(ram_rdata[COORD_BITS-1:0]))
					- (COORD_BITS+1)'(req_q.pos_y);
			end
			ST_SQ: begin
				ax_q <= dx_q[COORD_BITS] ? COORD_BITS'(-dx_q) : dx_q[COORD_BITS-1:0];
				ay_q <= dy_q[COORD_BITS] ? COORD_BITS'(-dy_q) : dy_q[COORD_BITS-1:0];
			end
			ST_MUL: begin
				sqx_q <= ax_q * ax_q;
				sqy_q <= ay_q * ay_q;
			end
			ST_CMP: d_q <= d_sum;
			ST_CSET: begin
				cx_q <= dx_q[COORD_BITS] ? -CW'(dx_q) : CW'(dx_q);
				cy_q <= dx_q[COORD_BITS] ? -CW'(dy_q) : CW'(dy_q);
				z_q  <= dx_q[COORD_BITS] ? 16'h8000 : 16'h0;
				it_q <= '0;
			end
			ST_NORM: begin
				if (!(norm_done || (dx_q == '0 && dy_q == '0))) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end
			end
			ST_ROT: begin
				if (!(dx_q == '0 && dy_q == '0)) begin
					cx_q <= nx;
					cy_q <= ny;
					z_q  <= nz;
				end
				it_q <= it_q + 1'b1;
			end
			ST_CONE: begin
				if (cone_ok) begin
					found_q <= 1'b1;
					best_q <= d_q;
					best_slot_q <= cur;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_q <= '0;
		else if (query_end) begin
			rsp_q.found <= (state_q == ST_CONE && cone_ok) ? 1'b1 : found_q;
			rsp_q.nearest_slot <= (state_q == ST_CONE && cone_ok) ? cur : best_slot_q;
			rsp_q.dist_sq <= (state_q == ST_CONE && cone_ok) ? d_q : best_q;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_no_done_write: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_WR |-> !done) else $error("done after write");
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.found |-> rsp.dist_sq == '0 && rsp.nearest_slot == '0)
		else $error("empty result not zero");
`endif
endmodule

// ===== verif/nearest_in_vision_cone_tb.sv =====
//------------------------------------------------------------------------------
// nearest_in_vision_cone_tb
// Self-checking bench for the nearest-in-vision-cone block. Slot writes and
// cone queries are fed through the start/busy handshake, with random gaps on
// the sender. A shadow slot table and a bit-exact bearing calculation predict
// each query answer. The monitor checks every done strobe against the oldest
// prediction.
//------------------------------------------------------------------------------
module nearest_in_vision_cone_tb;
	import nic_pkg::*;

	localparam int         N_RANDOM   = 520;
	localparam int         STALL_MAX  = 20000;
	localparam longint     DIST_SAT   = (64'd1 << 49) - 1;
	localparam longint     NORM_MIN   = 64'sd1 << 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	req_t   pending_reqs[$];
	rsp_t   expected_hits[$];
	longint shadow_x[SLOTS];
	longint shadow_y[SLOTS];
	bit     shadow_live[SLOTS];
	int     n_accepted = 0;
	int     n_errors = 0;
	int     quiet_cycles = 0;
	bit     drain_hold = 1'b0;

	nearest_in_vision_cone u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	function automatic req_t mk_req(logic op, int slot, logic live, logic self_in,
			int x, int y, int hd, int tn, int ap, int rg);
		req_t r;
		r.opcode        = op;
		r.slot          = slot[5:0];
		r.live          = live;
		r.self_in_table = self_in;
		r.pos_x         = x[23:0];
		r.pos_y         = y[23:0];
		r.heading       = hd[15:0];
		r.turn_offset   = tn[15:0];
		r.aperture      = ap[15:0];
		r.range_limit   = rg[22:0];
		return r;
	endfunction

	function automatic void enqueue_req(req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	function automatic logic [15:0] cone_bearing(longint x, longint y);
		longint z;
		longint xs;
		longint ys;
		z = 0;
		if (x == 0 && y == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32768;
		end
		while (x < NORM_MIN && y < NORM_MIN && y > -NORM_MIN) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(atan_tab(i[STEP_BITS-1:0]));
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(atan_tab(i[STEP_BITS-1:0]));
			end
		end
		return z[15:0];
	endfunction

	task automatic apply_request(req_t r);
		longint dx;
		longint dy;
		longint d;
		longint best;
		longint rsq;
		logic [15:0] rel;
		logic [17:0] amag;
		rsp_t hit;
		best = 0;
		hit = '0;
		if (r.opcode == OP_WRITE) begin
			if (r.live) begin
				shadow_x[r.slot] = longint'(r.pos_x);
				shadow_y[r.slot] = longint'(r.pos_y);
				shadow_live[r.slot] = 1'b1;
			end else begin
				shadow_live[r.slot] = 1'b0;
			end
			return;
		end
		rsq = longint'(r.range_limit) * longint'(r.range_limit);
		for (int i = 0; i < SLOTS; i++) begin
			if (!shadow_live[i] || (r.self_in_table && i == int'(r.slot)))
				continue;
			dx = shadow_x[i] - longint'(r.pos_x);
			dy = shadow_y[i] - longint'(r.pos_y);
			d = dx * dx + dy * dy;
			if (r.range_limit != 0 && !(d < rsq))
				continue;
			if (hit.found && !(d < best))
				continue;
			rel = cone_bearing(dx, dy) - r.heading - r.turn_offset;
			amag = rel[15] ? 18'(17'h10000 - rel) : 18'(rel);
			if (r.aperture != 0 && 2 * amag > 18'(r.aperture))
				continue;
			best = d;
			hit.found = 1'b1;
			hit.nearest_slot = i[5:0];
		end
		if (hit.found)
			hit.dist_sq = (best > DIST_SAT) ? DIST_SAT[48:0] : best[48:0];
		expected_hits = {expected_hits, hit};
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		n_errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		logic taken;
		int idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				apply_request(req);
				void'(pending_reqs.pop_front());
				n_accepted++;
				if (n_accepted == 100 || n_accepted == 250 || n_accepted == 400)
					drain_hold = 1'b1;
			end
			if (drain_hold && expected_hits.size() == 0)
				drain_hold = 1'b0;
			idle_pct = (n_accepted < 180) ? 17 : (n_accepted < 360) ? 81 : 0;
			if (!(start && !taken)) begin
				if (!drain_hold && pending_reqs.size() > 0
						&& $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					req <= pending_reqs[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : mon
		rsp_t want;
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				report("unexpected result", rsp, 0);
			end else begin
				want = expected_hits.pop_front();
				if (rsp.found !== want.found)
					report("found", rsp.found, want.found);
				if (rsp.nearest_slot !== want.nearest_slot)
					report("nearest_slot", rsp.nearest_slot, want.nearest_slot);
				if (rsp.dist_sq !== want.dist_sq)
					report("dist_sq", rsp.dist_sq, want.dist_sq);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_MAX) begin
				$display("[nearest_in_vision_cone] ERROR");
				$finish;
			end
		end
	end

	function automatic int pick_coord();
		if ($urandom_range(99) < 70)
			return $urandom_range(8192) - 4096;
		return int'($urandom);
	endfunction

	initial begin : stim
		int rg;
		int ap;
		logic op;
		for (int i = 0; i < SLOTS; i++)
			shadow_live[i] = 1'b0;

		enqueue_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 0, 1, 0, 256, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 63, 1, 0, 8388607, 8388607, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 1, 1, 0, -8388608, -8388608, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 2, 1, 0, 0, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 3, 1, 0, 256, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_QUERY, 2, 0, 1, 0, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_QUERY, 2, 0, 1, 0, 0, -32768, 0, 16384, 0));
		enqueue_req(mk_req(OP_QUERY, 2, 1, 1, 0, 0, 32767, 32767, 65535, 0));
		enqueue_req(mk_req(OP_QUERY, 2, 0, 1, 0, 0, 0, -32768, 0, 256));
		enqueue_req(mk_req(OP_QUERY, 2, 0, 1, 0, 0, 0, 0, 0, 257));
		enqueue_req(mk_req(OP_QUERY, 1, 0, 1, -8388608, -8388608, 0, 0, 0,
			8388607));
		enqueue_req(mk_req(OP_QUERY, 40, 0, 1, -8388608, -8388608, 8192, 0,
			16384, 0));
		enqueue_req(mk_req(OP_WRITE, 2, 0, 0, 77, 77, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_WRITE, 2, 1, 0, -512, 768, 0, 0, 0, 0));
		enqueue_req(mk_req(OP_QUERY, 63, 0, 1, 0, 0, 16384, 0, 1, 0));
		enqueue_req(mk_req(OP_QUERY, 63, 0, 1, 0, 0, 21000, 0, 4000, 0));
		enqueue_req(mk_req(OP_QUERY, 5, 1, 0, 0, 0, -16384, 16384, 32768,
			8388607));

		for (int n = 0; n < N_RANDOM; n++) begin
			op = (n < 30) ? OP_WRITE : ($urandom_range(99) < 45);
			case ($urandom_range(3))
				0: rg = 0;
				1: rg = $urandom_range(8191);
				default: rg = int'($urandom & ((32'd1 << $urandom_range(1, 23)) - 1));
			endcase
			case ($urandom_range(3))
				0: ap = 0;
				1: ap = 65535;
				default: ap = $urandom_range(65535);
			endcase
			enqueue_req(mk_req(op, $urandom_range(63),
				$urandom_range(99) < 85, 1'($urandom_range(1)), pick_coord(),
				pick_coord(), int'($urandom), int'($urandom), ap, rg));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || expected_hits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("[nearest_in_vision_cone] OK");
		else
			$display("[nearest_in_vision_cone] ERROR");
		$finish;
	end

endmodule
